FILE: rtl/rbt_pkg.sv
// shared types, constants and the arctangent table for the relative bearing block
`timescale 1ns / 1ps
`default_nettype none

package rbt_pkg;

	// default build parameters
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	// cordic datapath: offsets are 33 and 32 bits, scaled by 2^24, gain and diagonal headroom
	localparam int XY_W       = 60;
	localparam int FRAC_SHIFT = 24;
	localparam int DX_W       = 33;
	localparam int DY_W       = 32;

	// binary angle of half a circle
	localparam logic [31:0] Z_HALF = 32'h8000_0000;

	// heading to binary angle: hdg * 2^32 = hdg * (36000 * HDG_Q + HDG_R)
	localparam logic [16:0] HDG_Q     = 17'd119304;
	localparam logic [14:0] HDG_R     = 15'd23296;
	localparam logic [14:0] HDG_BIAS  = 15'd18000;
	localparam logic [15:0] HDG_DIV   = 16'd36000;
	// floor(2^47 / 36000), quotient estimate is exact or one short
	localparam logic [31:0] HDG_RECIP = 32'd3909374676;
	localparam int          HDG_RSH   = 47;
	localparam int          T_W       = 31;
	localparam int          REM_W     = 17;

	// payload handed from cell to cell
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [31:0]            z;
		logic [31:0]            h;
		logic                   nz;
	} cell_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_entry(input int i);
		logic [31:0] a;
		case (i)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			24: a = 32'h00000029;
			25: a = 32'h00000014;
			26: a = 32'h0000000A;
			27: a = 32'h00000005;
			28: a = 32'h00000003;
			29: a = 32'h00000001;
			30: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rbt_front.sv
// front end: offsets, zero checks, heading conversion and cordic start vector
`timescale 1ns / 1ps
`default_nettype none

module rbt_front import rbt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [31:0] target_lon,
	input  wire logic [30:0] target_lat,
	input  wire logic [31:0] current_lon,
	input  wire logic [30:0] current_lat,
	input  wire logic [15:0] heading_centideg,
	input  wire logic [15:0] speed_mag,
	output logic             out_valid,
	output cell_t            out_data
);

	logic [DX_W-1:0] dx_c;
	logic [DY_W-1:0] dy_c;
	logic            nz_c;
	logic [T_W-1:0]  t_c;
	logic [31:0]     hq_c;

	logic            vld_s1, vld_s2, vld_s3, vld_s4;
	logic [DX_W-1:0] dx_s1;
	logic [DY_W-1:0] dy_s1;
	logic            nz_s1, nz_s2, nz_s3;
	logic [T_W-1:0]  t_s1, t_s2;
	logic [31:0]     hq_s1, hq_s2, hq_s3;
	logic [62:0]     p_s2;
	logic [15:0]     q_s3;
	logic [REM_W-1:0] rem_s3;
	logic signed [XY_W-1:0] x_s2, y_s2, x_s3, y_s3;
	logic [31:0]     z_s2, z_s3;
	cell_t           data_s4;

	logic signed [XY_W-1:0] xe_c, ye_c;
	logic [15:0]     q_c;
	logic [T_W-1:0]  rem_c;

	// exact differences, one bit wider than the coordinates
	assign dx_c = {target_lon[31], target_lon} - {current_lon[31], current_lon};
	assign dy_c = {target_lat[30], target_lat} - {current_lat[30], current_lat};
	assign nz_c = (speed_mag != 16'd0) && ((dx_c != '0) || (dy_c != '0));
	assign t_c  = T_W'({15'd0, heading_centideg} * {16'd0, HDG_R}) + T_W'(HDG_BIAS);
	assign hq_c = 32'({16'd0, heading_centideg} * {15'd0, HDG_Q});

	// start vector, turned by half a circle when pointing south
	assign xe_c = {{(XY_W-DY_W-FRAC_SHIFT){dy_s1[DY_W-1]}}, dy_s1, {FRAC_SHIFT{1'b0}}};
	assign ye_c = {{(XY_W-DX_W-FRAC_SHIFT){dx_s1[DX_W-1]}}, dx_s1, {FRAC_SHIFT{1'b0}}};

	assign q_c   = p_s2[HDG_RSH+15:HDG_RSH];
	assign rem_c = t_s2 - T_W'({15'd0, q_c} * {15'd0, HDG_DIV});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			nz_s1 <= nz_c;
			t_s1  <= t_c;
			hq_s1 <= hq_c;

			p_s2  <= {32'd0, t_s1} * {31'd0, HDG_RECIP};
			t_s2  <= t_s1;
			hq_s2 <= hq_s1;
			nz_s2 <= nz_s1;
			if (dy_s1[DY_W-1]) begin
				x_s2 <= -xe_c;
				y_s2 <= -ye_c;
				z_s2 <= Z_HALF;
			end else begin
				x_s2 <= xe_c;
				y_s2 <= ye_c;
				z_s2 <= 32'd0;
			end

			q_s3   <= q_c;
			rem_s3 <= rem_c[REM_W-1:0];
			hq_s3  <= hq_s2;
			nz_s3  <= nz_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;

			// quotient correction when the estimate came out one short
			data_s4.h  <= hq_s3 + {16'd0, q_s3}
				+ {31'd0, (rem_s3 >= {1'b0, HDG_DIV})};
			data_s4.x  <= x_s3;
			data_s4.y  <= y_s3;
			data_s4.z  <= z_s3;
			data_s4.nz <= nz_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = data_s4;

endmodule

`default_nettype wire

FILE: rtl/rbt_cell.sv
// one cordic vectoring step, registered
`timescale 1ns / 1ps
`default_nettype none

module rbt_cell import rbt_pkg::*; #(
	parameter int STEP = 0
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  cell_t     in_data,
	output logic      out_valid,
	output cell_t     out_data
);

	localparam logic [31:0] ATAN = atan_entry(STEP);

	logic signed [XY_W-1:0] xs, ys;
	cell_t nxt;
	logic  valid_q;
	cell_t data_q;

	// arithmetic shifts round toward minus infinity
	assign xs = $signed(in_data.x) >>> STEP;
	assign ys = $signed(in_data.y) >>> STEP;

	always_comb begin
		nxt = in_data;
		if (!in_data.y[XY_W-1]) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ATAN;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

FILE: rtl/relative_bearing_to_target_top.sv
// top level: relative bearing from the direction of motion to a target
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  width  contents
// s_*      in   160    target/current position, heading, speed
// m_*      out  16+1   bearing angle in tdata, result flag in tuser
//
// one transfer is taken per clock while the skid slot is empty; the path is
// four front stages (offset, reciprocal multiply, remainder, correction),
// one cell per cordic step, and the output register.
// arst_n clears every valid bit; payload registers are not reset.
// a stalled output parks one result in a skid register; while it is full the
// whole pipeline holds and s_tready is low.

module relative_bearing_to_target_top import rbt_pkg::*; #(
	parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [31:0] target_lon, [62:32] target_lat, [94:63] current_lon,
	// [125:95] current_lat, [141:126] heading_centideg, [157:142] speed_mag, rest zero
	input  wire logic [159:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [15:0] bearing_angle
	output logic [15:0]       m_tdata,
	// [0] result_valid
	output logic              m_tuser
);

	// rounding to the kept angle precision
	localparam int          KEEP_BITS = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
	localparam int          RND_SHIFT = 32 - KEEP_BITS;
	localparam logic [31:0] RND_HALF  = 32'd1 << (RND_SHIFT - 1);
	localparam logic [31:0] RND_MASK  = ~((32'd1 << RND_SHIFT) - 32'd1);

	logic  en;
	logic  chain_vld [CORDIC_STEPS+1];
	cell_t chain_data [CORDIC_STEPS+1];

	// final angle from the end of the chain
	logic        take;
	logic [31:0] diff_c, rnd_c;
	logic [15:0] ang_c;
	logic        flag_c;
	logic        out_free;

	// output register and skid register
	logic        out_v_q, skid_v_q;
	logic [15:0] out_ang_q, skid_ang_q;
	logic        out_flag_q, skid_flag_q;

	// pipeline moves whenever the skid slot is empty
	assign en       = !skid_v_q;
	assign s_tready = en;

	rbt_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_valid         (s_tvalid),
		.target_lon       (s_tdata[31:0]),
		.target_lat       (s_tdata[62:32]),
		.current_lon      (s_tdata[94:63]),
		.current_lat      (s_tdata[125:95]),
		.heading_centideg (s_tdata[141:126]),
		.speed_mag        (s_tdata[157:142]),
		.out_valid        (chain_vld[0]),
		.out_data         (chain_data[0])
	);

	// row of cordic cells, one rotation each
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		rbt_cell #(
			.STEP (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (chain_vld[g]),
			.in_data   (chain_data[g]),
			.out_valid (chain_vld[g+1]),
			.out_data  (chain_data[g+1])
		);
	end

	// relative angle is heading minus bearing of the offset, rounded half up
	assign diff_c = chain_data[CORDIC_STEPS].h - chain_data[CORDIC_STEPS].z;
	assign rnd_c  = (diff_c + RND_HALF) & RND_MASK;
	assign flag_c = chain_data[CORDIC_STEPS].nz;
	// zero speed or zero offset gives a zero angle
	assign ang_c  = flag_c ? rnd_c[31:16] : 16'd0;

	assign take     = en && chain_vld[CORDIC_STEPS];
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_ang_q  <= skid_ang_q;
				out_flag_q <= skid_flag_q;
			end else if (take) begin
				out_ang_q  <= ang_c;
				out_flag_q <= flag_c;
			end
		end else if (take) begin
			skid_ang_q  <= ang_c;
			skid_flag_q <= flag_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_ang_q;
	assign m_tuser  = out_flag_q;

	// the skid slot is only used behind a held output
	a_skid_behind_out : assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full with output register empty");

	a_skid_fill_on_stall : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready))
		else $error("skid register filled without an output stall");

	a_no_take_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !s_tready)
		else $error("input transfer taken while skid register full");

	a_flag_zero_angle : assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_flag_q) |-> (out_ang_q == 16'd0))
		else $error("nonzero angle on a result without a valid bearing");

endmodule

`default_nettype wire

FILE: bench/relative_bearing_to_target_top_tb.sv
// self-checking bench for the relative bearing block against a cordic predictor
`timescale 1ns / 1ps

module relative_bearing_to_target_top_tb;
	import rbt_pkg::*;

	localparam int ANGLE_BITS   = ANGLE_BITS_DEF;
	localparam int CORDIC_STEPS = CORDIC_STEPS_DEF;
	// front stages, one cell per step and the output register
	localparam int LATENCY      = CORDIC_STEPS + 5;
	// cycles without any transfer before the run is declared hung
	localparam int HANG_LIMIT   = 4000;
	localparam int RANDOM_FIXES = 650;

	// atan(2^-i) in binary angle units, full circle = 2^32
	localparam logic [0:31][31:0] ARC_STEP = {
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// one navigation fix as it enters the block
	typedef struct packed {
		logic signed [31:0] tlon;
		logic signed [30:0] tlat;
		logic signed [31:0] clon;
		logic signed [30:0] clat;
		logic [15:0]        hdg;
		logic [15:0]        spd;
	} fix_t;

	// one bearing result as it leaves the block
	typedef struct packed {
		logic signed [15:0] angle;
		logic               ok;
	} bearing_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [15:0]  m_tdata;
	logic         m_tuser;

	fix_t     fix_pending [$];   // fixes still to be offered
	bearing_t bearing_due [$];   // bearings predicted, not yet seen
	fix_t     fix_held;          // fix currently on the slave side
	fix_t     fix_next;
	int       tx_idle = 0;       // percent of cycles the sender holds back
	int       rx_idle = 0;       // percent of cycles the receiver stalls
	int       mismatches = 0;
	int       quiet_cycles = 0;

	relative_bearing_to_target_top #(
		.ANGLE_BITS   (ANGLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// expected bearing for one fix: heading minus the cordic bearing of the offset
	function automatic bearing_t predict_bearing(input fix_t f);
		longint      dx, dy, x, y, xs, ys;
		logic [63:0] hwide;
		logic [31:0] hbin, zacc, diff, half_lsb, keep_mask;
		int          prec;
		bearing_t    b;
		dx = longint'(f.tlon) - longint'(f.clon);
		dy = longint'(f.tlat) - longint'(f.clat);
		b = '0;
		if (f.spd == 16'd0 || (dx == 0 && dy == 0)) begin
			return b;
		end
		hwide = ({48'd0, f.hdg} << 32) + 64'd18000;
		hbin  = 32'(hwide / 64'd36000);
		x = dy * 64'sd16777216;
		y = dx * 64'sd16777216;
		zacc = 32'd0;
		// offset in the southern half: turn it round by half a circle first
		if (x < 0) begin
			x = -x;
			y = -y;
			zacc = 32'h80000000;
		end
		for (int i = 0; i < ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS); i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				zacc = zacc + ARC_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				zacc = zacc - ARC_STEP[i];
			end
		end
		diff = hbin - zacc;
		// round to nearest at the output precision, ties upward, wrapping
		prec = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
		half_lsb  = 32'd1 << (31 - prec);
		keep_mask = ~((32'd1 << (32 - prec)) - 32'd1);
		diff = (diff + half_lsb) & keep_mask;
		b.angle = diff[31:16];
		b.ok    = 1'b1;
		return b;
	endfunction

	function automatic fix_t make_fix(input longint tlon, input longint tlat,
			input longint clon, input longint clat, input int hdg, input int spd);
		fix_t f;
		f.tlon = 32'(tlon);
		f.tlat = 31'(tlat);
		f.clon = 32'(clon);
		f.clat = 31'(clat);
		f.hdg  = 16'(hdg);
		f.spd  = 16'(spd);
		return f;
	endfunction

	function automatic longint any_lon();
		return longint'($urandom_range(3600000000, 0)) - 64'sd1800000000;
	endfunction

	function automatic longint any_lat();
		return longint'($urandom_range(1800000000, 0)) - 64'sd900000000;
	endfunction

	// small signed offset of random magnitude, never zero
	function automatic longint near_step();
		longint v;
		v = longint'($urandom_range((1 << $urandom_range(20, 0)), 1));
		return ($urandom_range(1, 0) == 1) ? -v : v;
	endfunction

	function automatic fix_t random_fix();
		fix_t   f;
		longint clon, clat;
		int     mode, hdg, spd;
		mode = $urandom_range(99, 0);
		clon = any_lon();
		clat = any_lat();
		hdg  = ($urandom_range(9, 0) == 0) ? $urandom_range(65535, 0)
			: $urandom_range(35999, 0);
		case ($urandom_range(19, 0))
			0, 1:    spd = 0;
			2:       spd = 65535;
			default: spd = $urandom_range(65535, 1);
		endcase
		if (mode < 40) begin
			// anywhere on the map
			f = make_fix(any_lon(), any_lat(), clon, clat, hdg, spd);
		end else if (mode < 72) begin
			// target close by, offsets spanning many scales
			f = make_fix(clon + near_step(), clat + near_step(), clon, clat, hdg, spd);
		end else if (mode < 84) begin
			// target on an axis of the map
			if ($urandom_range(1, 0) == 1) begin
				f = make_fix(clon, clat + near_step(), clon, clat, hdg, spd);
			end else begin
				f = make_fix(clon + near_step(), clat, clon, clat, hdg, spd);
			end
		end else if (mode < 87) begin
			// standing on the target
			f = make_fix(clon, clat, clon, clat, hdg, spd);
		end else begin
			// raw bit patterns over the full field widths
			f = make_fix(longint'($signed($urandom())), longint'($signed($urandom())),
				longint'($signed($urandom())), longint'($signed($urandom())),
				$urandom_range(65535, 0), $urandom_range(65535, 0));
		end
		return f;
	endfunction

	// driver: offers the next pending fix when the slave side is free, holding back at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			// transfer taken: its bearing is now owed
			if (s_tvalid && s_tready) begin
				bearing_due.push_back(predict_bearing(fix_held));
			end
			if (!s_tvalid || s_tready) begin
				if (fix_pending.size() != 0 && $urandom_range(99, 0) >= tx_idle) begin
					fix_next = fix_pending.pop_front();
					fix_held <= fix_next;
					s_tvalid <= 1'b1;
					// tdata: tlon, tlat, clon, clat, heading, speed from bit 0 up
					s_tdata  <= {2'b00, fix_next.spd, fix_next.hdg, fix_next.clat,
						fix_next.clon, fix_next.tlat, fix_next.tlon};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each bearing against the oldest one owed, then stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (bearing_due.size() == 0) begin
					$error("unexpected bearing transfer: angle %0d, flag %0b",
						$signed(m_tdata), m_tuser);
					mismatches++;
				end else begin
					if (m_tdata !== bearing_due[0].angle) begin
						$error("bearing_angle: expected %0d, got %0d",
							bearing_due[0].angle, $signed(m_tdata));
						mismatches++;
					end
					if (m_tuser !== bearing_due[0].ok) begin
						$error("result_valid: expected %0b, got %0b",
							bearing_due[0].ok, m_tuser);
						mismatches++;
					end
					void'(bearing_due.pop_front());
				end
			end
			m_tready <= ($urandom_range(99, 0) >= rx_idle);
		end
	end

	// watchdog: any transfer on either side counts as progress
	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
			quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("[relative_bearing_to_target_top] ERROR");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					tx_idle = 10;
					rx_idle = 82;
				end
				1: begin
					tx_idle = 82;
					rx_idle = 10;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			if (phase == 0) begin
				// not moving: no bearing whatever the offset
				fix_pending.push_back(make_fix(1000, 2000, 0, 0, 4500, 0));
				// on the target: no bearing
				fix_pending.push_back(make_fix(-55, 77, -55, 77, 4500, 9));
				fix_pending.push_back(make_fix(0, 0, 0, 0, 0, 0));
				// target dead ahead, north
				fix_pending.push_back(make_fix(0, 500, 0, 0, 0, 1));
				// target straight behind comes out as the most negative angle
				fix_pending.push_back(make_fix(0, -500, 0, 0, 0, 1));
				fix_pending.push_back(make_fix(100, 0, 0, 0, 18000, 1));
				// targets due east and due west
				fix_pending.push_back(make_fix(300, 0, 0, 0, 0, 65535));
				fix_pending.push_back(make_fix(-300, 0, 0, 0, 0, 65535));
				fix_pending.push_back(make_fix(0, 12345, 0, 0, 35999, 3));
				fix_pending.push_back(make_fix(0, 1, 0, 0, 18000, 3));
				// heading beyond a full circle wraps
				fix_pending.push_back(make_fix(777, 0, 0, 0, 65535, 3));
				fix_pending.push_back(make_fix(-1, -1, 0, 0, 36000, 3));
				// corners of the map
				fix_pending.push_back(make_fix(1800000000, 900000000,
					-1800000000, -900000000, 9000, 200));
				fix_pending.push_back(make_fix(-1800000000, -900000000,
					1800000000, 900000000, 27000, 200));
				fix_pending.push_back(make_fix(1800000000, -900000000,
					-1800000000, 900000000, 13500, 200));
				// full-width extremes, offsets beyond the map range
				fix_pending.push_back(make_fix(2147483647, 1073741823,
					-2147483648, -1073741824, 100, 1));
				fix_pending.push_back(make_fix(-2147483648, -1073741824,
					2147483647, 1073741823, 100, 1));
				fix_pending.push_back(make_fix(-1, -1, 0, 0, 65535, 65535));
				// smallest offsets
				fix_pending.push_back(make_fix(1, 1, 0, 0, 4500, 7));
				fix_pending.push_back(make_fix(1, -1, 0, 0, 31500, 7));
				fix_pending.push_back(make_fix(-1, 0, 0, 0, 27000, 7));
				fix_pending.push_back(make_fix(0, 0, 1, 0, 0, 7));
			end
			for (int n = 0; n < RANDOM_FIXES / 3; n++) begin
				fix_pending.push_back(random_fix());
			end
			while (fix_pending.size() != 0 || s_tvalid) @(posedge clk);
		end

		// drain, then give the pipeline time to show anything extra
		while (bearing_due.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0) begin
			$display("[relative_bearing_to_target_top] OK");
		end else begin
			$display("[relative_bearing_to_target_top] ERROR");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rbt_pkg.sv
rtl/rbt_front.sv
rtl/rbt_cell.sv
rtl/relative_bearing_to_target_top.sv
bench/relative_bearing_to_target_top_tb.sv
